### hw/rtl/sdt_pkg.sv
`timescale 1ns / 1ps
package sdt_pkg;
  localparam int TABLE_DEPTH = 16;
  localparam int SLOT_W = $clog2(TABLE_DEPTH);
  localparam int OUI_ENTRIES = 31;
  localparam logic [47:0] HOTSPOT_PREFIX = 48'h466C6F636B2D;
  localparam logic [6:0] HOTSPOT_CONF = 7'd80;
  localparam logic [6:0] OUI_CONF = 7'd20;
  localparam logic [6:0] BUMP_LIMIT = 7'd95;
  localparam logic [6:0] BUMP_STEP = 7'd5;
  localparam logic [31:0] STALE_RESET = 32'd60000;
  localparam logic [1:0] LABEL_HOTSPOT = 2'd1;
  localparam logic [1:0] LABEL_OUI = 2'd2;
  // entry payload: addr 48, strength 8, kind 1, label 2, conf 7, time 32
  localparam int ENTRY_W = 98;

  typedef enum logic [1:0] {
    OP_WIFI  = 2'd0,
    OP_BLE   = 2'd1,
    OP_PRUNE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_FETCH,
    ST_WAIT,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic [47:0] addr;
    logic signed [7:0] strength;
    logic kind;
    logic [1:0] label;
    logic [6:0] conf;
    logic [31:0] stamp;
  } entry_t;

  function automatic logic oui_hit(input logic [23:0] oui);
    logic [23:0] rom [OUI_ENTRIES];
    logic hit;
    rom = '{24'h70C94E, 24'h3C9180, 24'hD8F3BC, 24'h803049, 24'hB83532, 24'h145AFC,
           24'h744CA1, 24'h083A88, 24'h9C2F9D, 24'hC03532, 24'h940853, 24'hE4AAEA,
           24'hF46ADD, 24'hF8A2D6, 24'h24B2B9, 24'h00F48D, 24'hD03957, 24'hE8D0FC,
           24'hE04F43, 24'hB81EA4, 24'h700894, 24'h588E81, 24'hEC1BBD, 24'h3C71BF,
           24'h5800E3, 24'h9035EA, 24'h5C93A2, 24'h646E69, 24'h4827EA, 24'hA4CF12,
           24'h826BF2};
    hit = 1'b0;
    for (int i = 0; i < OUI_ENTRIES; i++) begin
      if (rom[i] == oui) hit = 1'b1;
    end
    return hit;
  endfunction
endpackage

### hw/rtl/sdt_ram.sv
`timescale 1ns / 1ps
module sdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/signature_detection_table.sv
`timescale 1ns / 1ps
// Channel | Ports                                   | Handshake
// in      | in_operation .. in_slot_select          | start & !busy
// out     | out_matched .. out_last_seen_ms         | out_strobe, one cycle
// cfg     | cfg_we, cfg_wdata (stale_limit_ms)      | cfg_we
// A sighting with a signature scans all slots through the RAM read port, one per
// cycle, then fetches and writes back the chosen slot. A prune scans all slots too;
// a read fetches the selected slot; a sighting without a signature skips the scan.
// Reset (synchronous, rst_n low) clears all used bits and the control state;
// entry RAM contents are undefined until written.
// The receiver cannot stall: results are shown for one cycle only.
module signature_detection_table (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_operation,
  input  logic [47:0]       in_address,
  input  logic signed [7:0] in_signal_strength,
  input  logic [47:0]       in_ssid_head,
  input  logic [31:0]       in_now_ms,
  input  logic [3:0]        in_slot_select,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata,
  output logic              out_strobe,
  output logic              out_matched,
  output logic [3:0]        out_slot,
  output logic              out_entry_valid,
  output logic [47:0]       out_stored_address,
  output logic signed [7:0] out_best_strength,
  output logic              out_device_kind,
  output logic [1:0]        out_label_code,
  output logic [6:0]        out_confidence,
  output logic [31:0]       out_last_seen_ms
);
  localparam int SW = sdt_pkg::SLOT_W;

  sdt_pkg::state_t state_r, state_nxt;
  logic [31:0] limit_r;
  logic [sdt_pkg::TABLE_DEPTH-1:0] used_r, used_nxt;
  logic [1:0]  op_r;
  logic [47:0] addr_r;
  logic signed [7:0] rssi_r;
  logic [31:0] now_r;
  logic [6:0]  sconf_r;
  logic [1:0]  slabel_r;
  logic [3:0]  sel_r;
  logic [SW-1:0] idx_r, idx_nxt;       // slot being issued to the RAM
  logic [SW-1:0] cmp_r;                // slot whose data arrives now
  logic hit_r, free_r, found_hit, found_free;
  logic [SW-1:0] hit_idx_r, open_idx_r, old_idx_r;
  logic [31:0] old_t_r;
  logic [SW-1:0] tgt_r;

  logic ram_we;
  logic [SW-1:0] ram_raddr, ram_waddr;
  sdt_pkg::entry_t rd, wr;

  logic [SW-1:0] last_idx;
  assign last_idx = SW'(sdt_pkg::TABLE_DEPTH - 1);

  sdt_ram #(.WIDTH(sdt_pkg::ENTRY_W), .DEPTH(sdt_pkg::TABLE_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(wr),
    .raddr(ram_raddr), .rdata(rd)
  );

  // signature decode of the incoming transaction
  logic in_hs, in_oui;
  assign in_hs  = (in_operation == sdt_pkg::OP_WIFI) &&
                  (in_ssid_head == sdt_pkg::HOTSPOT_PREFIX);
  assign in_oui = sdt_pkg::oui_hit(in_address[47:24]);

  // merge signature into the fetched or fresh entry
  sdt_pkg::entry_t base;
  always_comb begin
    base = rd;
    if (!hit_r) begin
      base.addr = addr_r;
      base.strength = rssi_r;
      base.kind = 1'b0;
      base.label = 2'd0;
      base.conf = 7'd0;
    end
    wr = base;
    if (sconf_r > base.conf) begin
      wr.kind = 1'b1;
      wr.label = slabel_r;
      wr.conf = sconf_r;
    end else if (sconf_r == base.conf && base.conf < sdt_pkg::BUMP_LIMIT) begin
      wr.conf = base.conf + sdt_pkg::BUMP_STEP;
    end
    if (rssi_r > base.strength) wr.strength = rssi_r;
    wr.stamp = now_r;
  end

  // next state and outputs
  logic out_nxt_strobe, out_nxt_matched, out_nxt_valid;
  logic [3:0] out_nxt_slot;
  sdt_pkg::entry_t out_nxt_e;
  logic live;
  assign live = used_r[cmp_r];

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    used_nxt = used_r;
    ram_raddr = idx_r;
    ram_we = 1'b0;
    ram_waddr = tgt_r;
    out_nxt_strobe = 1'b0;
    out_nxt_matched = 1'b0;
    out_nxt_valid = 1'b0;
    out_nxt_slot = 4'd0;
    out_nxt_e = '0;
    found_hit = hit_r || (live && rd.addr == addr_r);
    found_free = free_r || !live;
    unique case (state_r)
      sdt_pkg::ST_IDLE: begin
        ram_raddr = in_slot_select[SW-1:0];
        idx_nxt = '0;
        if (start) begin
          unique case (in_operation)
            sdt_pkg::OP_WIFI, sdt_pkg::OP_BLE: begin
              if (in_hs || in_oui) begin
                ram_raddr = '0;
                idx_nxt = SW'(1);
                state_nxt = (sdt_pkg::TABLE_DEPTH == 1) ? sdt_pkg::ST_LAST
                                                         : sdt_pkg::ST_SCAN;
              end else begin
                out_nxt_strobe = 1'b1;
              end
            end
            sdt_pkg::OP_PRUNE: begin
              ram_raddr = '0;
              idx_nxt = SW'(1);
              state_nxt = (sdt_pkg::TABLE_DEPTH == 1) ? sdt_pkg::ST_LAST
                                                       : sdt_pkg::ST_SCAN;
            end
            default: state_nxt = sdt_pkg::ST_WAIT;
          endcase
        end
      end
      sdt_pkg::ST_SCAN: begin
        if (idx_r == last_idx) state_nxt = sdt_pkg::ST_LAST;
        else idx_nxt = idx_r + SW'(1);
        if (op_r == sdt_pkg::OP_PRUNE && live &&
            (now_r - rd.stamp) > limit_r) used_nxt[cmp_r] = 1'b0;
      end
      sdt_pkg::ST_LAST: begin
        if (op_r == sdt_pkg::OP_PRUNE) begin
          if (live && (now_r - rd.stamp) > limit_r) used_nxt[cmp_r] = 1'b0;
          out_nxt_strobe = 1'b1;
          state_nxt = sdt_pkg::ST_IDLE;
        end else begin
          state_nxt = sdt_pkg::ST_FETCH;
        end
      end
      sdt_pkg::ST_FETCH: begin
        ram_raddr = tgt_r;
        state_nxt = sdt_pkg::ST_WRITE;
      end
      sdt_pkg::ST_WRITE: begin
        ram_we = 1'b1;
        used_nxt[tgt_r] = 1'b1;
        out_nxt_strobe = 1'b1;
        out_nxt_matched = 1'b1;
        out_nxt_valid = 1'b1;
        out_nxt_slot = 4'(tgt_r);
        out_nxt_e = wr;
        state_nxt = sdt_pkg::ST_IDLE;
      end
      sdt_pkg::ST_WAIT: begin
        // read data for the selected slot is here
        out_nxt_strobe = 1'b1;
        out_nxt_slot = sel_r;
        if ({{(5-SW){1'b0}}, sel_r[SW-1:0]} == {1'b0, sel_r} &&
            32'(sel_r) < sdt_pkg::TABLE_DEPTH && used_r[sel_r[SW-1:0]]) begin
          out_nxt_valid = 1'b1;
          out_nxt_e = rd;
        end
        state_nxt = sdt_pkg::ST_IDLE;
      end
      default: state_nxt = sdt_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdt_pkg::ST_IDLE;
      used_r <= '0;
      limit_r <= sdt_pkg::STALE_RESET;
      out_strobe <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r <= used_nxt;
      out_strobe <= out_nxt_strobe;
      if (cfg_we) limit_r <= cfg_wdata;
    end
  end

  // scan bookkeeping and payload
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    cmp_r <= ram_raddr;
    if (state_r == sdt_pkg::ST_IDLE && start) begin
      op_r <= in_operation;
      addr_r <= in_address;
      rssi_r <= in_signal_strength;
      now_r <= in_now_ms;
      sel_r <= in_slot_select;
      sconf_r <= in_hs ? sdt_pkg::HOTSPOT_CONF : sdt_pkg::OUI_CONF;
      slabel_r <= in_hs ? sdt_pkg::LABEL_HOTSPOT : sdt_pkg::LABEL_OUI;
      hit_r <= 1'b0;
      free_r <= 1'b0;
      old_t_r <= 32'hFFFFFFFF;
      old_idx_r <= '0;
    end else if (state_r == sdt_pkg::ST_SCAN || state_r == sdt_pkg::ST_LAST) begin
      // compare the slot whose data arrived this cycle
      if (!hit_r && live && rd.addr == addr_r) hit_idx_r <= cmp_r;
      if (!free_r && !live) open_idx_r <= cmp_r;
      if (live && rd.stamp < old_t_r) begin
        old_t_r <= rd.stamp;
        old_idx_r <= cmp_r;
      end
      hit_r <= found_hit;
      free_r <= found_free;
    end
    if (state_r == sdt_pkg::ST_LAST)
      tgt_r <= hit_r ? hit_idx_r : free_r ? open_idx_r : old_idx_r;
    if (state_r == sdt_pkg::ST_LAST && !hit_r && live && rd.addr == addr_r)
      tgt_r <= cmp_r;
    else if (state_r == sdt_pkg::ST_LAST && !hit_r && !free_r && !live)
      tgt_r <= cmp_r;
    else if (state_r == sdt_pkg::ST_LAST && !hit_r && !free_r && live &&
             rd.stamp < old_t_r)
      tgt_r <= cmp_r;
    out_matched <= out_nxt_matched;
    out_slot <= out_nxt_slot;
    out_entry_valid <= out_nxt_valid;
    out_stored_address <= out_nxt_e.addr;
    out_best_strength <= out_nxt_e.strength;
    out_device_kind <= out_nxt_e.kind;
    out_label_code <= out_nxt_e.label;
    out_confidence <= out_nxt_e.conf;
    out_last_seen_ms <= out_nxt_e.stamp;
  end

  assign busy = (state_r != sdt_pkg::ST_IDLE);

  // hit on a fresh sighting flag ties to the fetched entry
  logic hit_fetch_r;
  always_ff @(posedge clk) begin
    if (state_r == sdt_pkg::ST_LAST) hit_fetch_r <= found_hit;
  end

  // checks
  a_write_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> out_strobe && out_matched) else $error("write without result");
  a_busy_nostrobe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sdt_pkg::ST_WRITE) |=> !busy) else $error("write did not finish");
  a_match_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_matched) |-> out_entry_valid) else $error("match not valid");
  a_used_set: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> used_r[$past(tgt_r)]) else $error("used bit not set");
  a_fetch_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sdt_pkg::ST_WRITE && hit_fetch_r) |-> wr.addr == addr_r)
    else $error("hit address mismatch");
endmodule

### verif/signature_detection_table_tb.sv
`timescale 1ns / 1ps
module signature_detection_table_tb;

  typedef struct {
    logic        matched;
    logic [3:0]  slot;
    logic        entry_valid;
    logic [47:0] stored_address;
    logic [7:0]  best_strength;
    logic        device_kind;
    logic [1:0]  label_code;
    logic [6:0]  confidence;
    logic [31:0] last_seen_ms;
  } sighting_report_t;

  // Shadow copy of the detection table; predicts one report per transaction
  class table_scoreboard;
    logic        used [sdt_pkg::TABLE_DEPTH];
    logic [47:0] addr [sdt_pkg::TABLE_DEPTH];
    logic signed [7:0] rssi [sdt_pkg::TABLE_DEPTH];
    logic        kind [sdt_pkg::TABLE_DEPTH];
    logic [1:0]  label [sdt_pkg::TABLE_DEPTH];
    logic [6:0]  conf [sdt_pkg::TABLE_DEPTH];
    logic [31:0] stamp [sdt_pkg::TABLE_DEPTH];
    logic [31:0] stale_limit;
    sighting_report_t pending [$];
    int errors;

    function new();
      stale_limit = sdt_pkg::STALE_RESET;
      errors = 0;
      for (int i = 0; i < sdt_pkg::TABLE_DEPTH; i++) begin
        used[i] = '0; addr[i] = '0; rssi[i] = '0; kind[i] = '0;
        label[i] = '0; conf[i] = '0; stamp[i] = '0;
      end
    endfunction

    function bit known_oui(logic [23:0] oui);
      logic [23:0] rom [31];
      rom = '{24'h70C94E, 24'h3C9180, 24'hD8F3BC, 24'h803049, 24'hB83532, 24'h145AFC,
              24'h744CA1, 24'h083A88, 24'h9C2F9D, 24'hC03532, 24'h940853, 24'hE4AAEA,
              24'hF46ADD, 24'hF8A2D6, 24'h24B2B9, 24'h00F48D, 24'hD03957, 24'hE8D0FC,
              24'hE04F43, 24'hB81EA4, 24'h700894, 24'h588E81, 24'hEC1BBD, 24'h3C71BF,
              24'h5800E3, 24'h9035EA, 24'h5C93A2, 24'h646E69, 24'h4827EA, 24'hA4CF12,
              24'h826BF2};
      foreach (rom[i]) if (rom[i] == oui) return 1'b1;
      return 1'b0;
    endfunction

    function sighting_report_t slot_report(logic m, int s);
      sighting_report_t r;
      r = '{default: '0};
      r.matched = m;
      r.slot = s[3:0];
      if (used[s]) begin
        r.entry_valid = 1'b1;
        r.stored_address = addr[s];
        r.best_strength = rssi[s];
        r.device_kind = kind[s];
        r.label_code = label[s];
        r.confidence = conf[s];
        r.last_seen_ms = stamp[s];
      end
      return r;
    endfunction

    function int merge_sighting(logic [47:0] a, logic [6:0] c, logic [1:0] l,
                                logic signed [7:0] rs, logic [31:0] now);
      int open_idx, old_idx, s;
      logic [31:0] oldest;
      open_idx = -1; old_idx = 0; oldest = 32'hFFFFFFFF; s = -1;
      for (int i = 0; i < sdt_pkg::TABLE_DEPTH; i++) begin
        if (s < 0) begin
          if (used[i] && addr[i] == a) s = i;
          else begin
            if (!used[i] && open_idx < 0) open_idx = i;
            if (used[i] && stamp[i] < oldest) begin
              oldest = stamp[i]; old_idx = i;
            end
          end
        end
      end
      if (s < 0) begin
        s = (open_idx >= 0) ? open_idx : old_idx;
        used[s] = 1'b1; addr[s] = a; rssi[s] = rs;
        kind[s] = '0; label[s] = '0; conf[s] = '0; stamp[s] = '0;
      end
      if (c > conf[s]) begin
        kind[s] = 1'b1; label[s] = l; conf[s] = c;
      end else if (c == conf[s] && conf[s] < sdt_pkg::BUMP_LIMIT) begin
        conf[s] = conf[s] + sdt_pkg::BUMP_STEP;
      end
      if (rs > rssi[s]) rssi[s] = rs;
      stamp[s] = now;
      return s;
    endfunction

    function void note_input(sdt_pkg::op_t op, logic [47:0] a, logic signed [7:0] rs,
                             logic [47:0] ssid, logic [31:0] now, logic [3:0] sel);
      sighting_report_t r;
      int s;
      r = '{default: '0};
      case (op)
        sdt_pkg::OP_WIFI, sdt_pkg::OP_BLE: begin
          if (op == sdt_pkg::OP_WIFI && ssid == sdt_pkg::HOTSPOT_PREFIX) begin
            s = merge_sighting(a, sdt_pkg::HOTSPOT_CONF, sdt_pkg::LABEL_HOTSPOT, rs, now);
            r = slot_report(1'b1, s);
          end else if (known_oui(a[47:24])) begin
            s = merge_sighting(a, sdt_pkg::OUI_CONF, sdt_pkg::LABEL_OUI, rs, now);
            r = slot_report(1'b1, s);
          end
        end
        sdt_pkg::OP_PRUNE: begin
          for (int i = 0; i < sdt_pkg::TABLE_DEPTH; i++)
            if (used[i] && (now - stamp[i]) > stale_limit) used[i] = 1'b0;
        end
        default: r = slot_report(1'b0, int'(sel));
      endcase
      pending.push_back(r);
    endfunction

    function void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(sighting_report_t act);
      sighting_report_t e;
      if (pending.size() == 0) begin
        $error("report with no transaction outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      check_field("matched", 64'(e.matched), 64'(act.matched));
      check_field("slot", 64'(e.slot), 64'(act.slot));
      check_field("entry_valid", 64'(e.entry_valid), 64'(act.entry_valid));
      check_field("stored_address", 64'(e.stored_address), 64'(act.stored_address));
      check_field("best_strength", 64'(e.best_strength), 64'(act.best_strength));
      check_field("device_kind", 64'(e.device_kind), 64'(act.device_kind));
      check_field("label_code", 64'(e.label_code), 64'(act.label_code));
      check_field("confidence", 64'(e.confidence), 64'(act.confidence));
      check_field("last_seen_ms", 64'(e.last_seen_ms), 64'(act.last_seen_ms));
    endfunction
  endclass

  logic clk, rst_n, start, busy, cfg_we;
  logic [1:0] in_operation;
  logic [47:0] in_address, in_ssid_head, out_stored_address;
  logic signed [7:0] in_signal_strength, out_best_strength;
  logic [31:0] in_now_ms, cfg_wdata, out_last_seen_ms;
  logic [3:0] in_slot_select, out_slot;
  logic out_strobe, out_matched, out_entry_valid, out_device_kind;
  logic [1:0] out_label_code;
  logic [6:0] out_confidence;

  table_scoreboard sb;
  logic [47:0] known_addr [8];
  logic [31:0] clock_ms;
  logic [23:0] oui_pick [4];

  signature_detection_table DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_address(in_address),
    .in_signal_strength(in_signal_strength), .in_ssid_head(in_ssid_head),
    .in_now_ms(in_now_ms), .in_slot_select(in_slot_select),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_strobe(out_strobe), .out_matched(out_matched), .out_slot(out_slot),
    .out_entry_valid(out_entry_valid), .out_stored_address(out_stored_address),
    .out_best_strength(out_best_strength), .out_device_kind(out_device_kind),
    .out_label_code(out_label_code), .out_confidence(out_confidence),
    .out_last_seen_ms(out_last_seen_ms)
  );

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  // Sample reports at the rising edge
  always @(posedge clk) begin
    sighting_report_t r;
    if (rst_n && out_strobe) begin
      r.matched = out_matched; r.slot = out_slot; r.entry_valid = out_entry_valid;
      r.stored_address = out_stored_address; r.best_strength = out_best_strength;
      r.device_kind = out_device_kind; r.label_code = out_label_code;
      r.confidence = out_confidence; r.last_seen_ms = out_last_seen_ms;
      sb.check_result(r);
    end
  end

  // Hold off a random number of cycles, mostly short
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    repeat (n) @(negedge clk);
  endtask

  // Issue one transaction at the next falling edge and wait for its acceptance
  task automatic send_op(sdt_pkg::op_t op, logic [47:0] a, logic signed [7:0] rs,
                         logic [47:0] ssid, logic [31:0] now, logic [3:0] sel);
    @(negedge clk);
    in_operation <= op; in_address <= a; in_signal_strength <= rs;
    in_ssid_head <= ssid; in_now_ms <= now; in_slot_select <= sel;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_input(op, a, rs, ssid, now, sel);
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Drain outstanding reports, then let the block settle
  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  task automatic write_limit(logic [31:0] v);
    drain();
    cfg_wdata <= v; cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.stale_limit = v;
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  // Random transaction: a prune, a read, or a sighting biased toward known addresses and matching signatures
  task automatic random_op();
    int k;
    logic [47:0] a, ssid;
    sdt_pkg::op_t op;
    k = $urandom_range(0, 99);
    clock_ms = clock_ms + $urandom_range(0, 3000);
    if (k < 8) begin
      send_op(sdt_pkg::OP_PRUNE, rand48(), 8'($urandom()), rand48(),
              ($urandom_range(0, 9) == 0) ? $urandom() : clock_ms, 4'($urandom()));
      return;
    end
    if (k < 25) begin
      send_op(sdt_pkg::OP_READ, rand48(), 8'($urandom()), rand48(), $urandom(),
              4'($urandom()));
      return;
    end
    case ($urandom_range(0, 3))
      0: a = rand48();
      1: a = {oui_pick[$urandom_range(0, 3)], 24'($urandom())};
      default: a = known_addr[$urandom_range(0, 7)];
    endcase
    op = ($urandom_range(0, 1) == 0) ? sdt_pkg::OP_WIFI : sdt_pkg::OP_BLE;
    ssid = ($urandom_range(0, 2) == 0) ? sdt_pkg::HOTSPOT_PREFIX :
           ($urandom_range(0, 1) ? rand48() : 48'h0);
    send_op(op, a, 8'($urandom()), ssid, clock_ms, 4'($urandom()));
  endtask

  initial begin
    #20_000_000;
    $display("signature_detection_table verification failed");
    $finish;
  end

  initial begin
    sb = new();
    rst_n = 1'b0; start = 1'b0; cfg_we = 1'b0; cfg_wdata = '0;
    in_operation = sdt_pkg::OP_WIFI; in_address = '0; in_signal_strength = '0;
    in_ssid_head = '0; in_now_ms = '0; in_slot_select = '0;
    clock_ms = 32'd1000;
    oui_pick = '{24'h70C94E, 24'h826BF2, 24'hA4CF12, 24'h00F48D};
    for (int i = 0; i < 8; i++)
      known_addr[i] = {(i < 4) ? oui_pick[i] : 24'($urandom()), 24'($urandom())};
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: extremes, both signatures, bumps, read beyond use, prune
    send_op(sdt_pkg::OP_READ, '0, '0, '0, '0, 4'd0);
    send_op(sdt_pkg::OP_READ, '1, '1, '1, '1, 4'd15);
    send_op(sdt_pkg::OP_WIFI, 48'h123456789ABC, -8'sd128, sdt_pkg::HOTSPOT_PREFIX,
            32'd10, 4'd0);
    send_op(sdt_pkg::OP_WIFI, 48'h123456789ABC, 8'sd127, sdt_pkg::HOTSPOT_PREFIX,
            32'd20, 4'd0);
    send_op(sdt_pkg::OP_BLE, 48'h123456789ABC, 8'sd5, sdt_pkg::HOTSPOT_PREFIX,
            32'd30, 4'd0);
    send_op(sdt_pkg::OP_BLE, 48'h70C94E000001, -8'sd40, '0, 32'd40, 4'd0);
    send_op(sdt_pkg::OP_BLE, 48'h70C94E000001, -8'sd50, '0, 32'd50, 4'd0);
    send_op(sdt_pkg::OP_WIFI, 48'h70C94E000001, -8'sd30, sdt_pkg::HOTSPOT_PREFIX,
            32'd60, 4'd0);
    send_op(sdt_pkg::OP_WIFI, 48'hFFFFFFFFFFFF, 8'sd0, 48'hFFFFFFFFFFFF,
            32'hFFFFFFFF, 4'd0);
    send_op(sdt_pkg::OP_WIFI, 48'h826BF2FFFFFF, 8'sd1, 48'h466C6F636B2E,
            32'hFFFFFFFF, 4'd0);
    for (int i = 0; i < 16; i++)
      send_op(sdt_pkg::OP_BLE, {24'hA4CF12, 24'(i)}, -8'sd60, '0, 32'(100 + i), 4'd0);
    for (int i = 0; i < 4; i++)
      send_op(sdt_pkg::OP_READ, '0, '0, '0, '0, 4'(i * 5));
    send_op(sdt_pkg::OP_PRUNE, '0, '0, '0, 32'd60110, 4'd0);
    send_op(sdt_pkg::OP_READ, '0, '0, '0, '0, 4'd12);

    write_limit(32'd0);
    send_op(sdt_pkg::OP_PRUNE, '0, '0, '0, 32'd60200, 4'd0);
    write_limit(32'hFFFFFFFF);
    send_op(sdt_pkg::OP_BLE, 48'h70C94E0000AA, 8'sd0, '0, 32'd5, 4'd0);
    send_op(sdt_pkg::OP_PRUNE, '0, '0, '0, 32'd4, 4'd0);

    // Random phases under several stale limits
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_limit(sdt_pkg::STALE_RESET);
        1: write_limit(32'd0);
        2: write_limit(32'd5000);
        3: write_limit(32'hFFFFFFFF);
        4: write_limit($urandom());
        default: write_limit(32'd20000);
      endcase
      for (int n = 0; n < 315; n++) begin
        if ($urandom_range(0, 2) == 0) idle_gap();
        random_op();
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("signature_detection_table verification clean");
    else
      $display("signature_detection_table verification failed");
    $finish;
  end
endmodule
